@@ rtl/core/mira_pkg.sv @@
// Package for the multilane integer register ALU: word types, action codes
// and register-file dimensions. No dependencies.
`default_nettype none

package mira_pkg;

  // Register-file geometry. Both counts are powers of two, so the low index
  // bits of a field select a lane or a register directly.
  localparam int LaneCount  = 8;
  localparam int RegCount   = 8;
  localparam int LaneIdxW   = $clog2(LaneCount);
  localparam int RegIdxW    = $clog2(RegCount);
  localparam int DataW      = 64;
  localparam int HalfW      = DataW / 2;
  localparam int RotW       = $clog2(DataW);

  typedef enum logic [3:0] {
    ACT_IADD_RS = 4'd0,
    ACT_ISUB    = 4'd1,
    ACT_IMUL    = 4'd2,
    ACT_INEG    = 4'd3,
    ACT_IXOR    = 4'd4,
    ACT_IROR    = 4'd5,
    ACT_IROL    = 4'd6,
    ACT_ISWAP   = 4'd7,
    ACT_IMULH   = 4'd8,
    ACT_ISMULH  = 4'd9,
    ACT_WRITE   = 4'd10,
    ACT_READ    = 4'd11
  } act_e;

  typedef struct packed {
    logic [3:0]       action;
    logic [2:0]       dst_reg;
    logic [2:0]       src_reg;
    logic [1:0]       shift_amount;
    logic [DataW-1:0] immediate;
    logic [2:0]       lane_select;
    logic             end_of_program;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] reg_value;
    logic             program_done;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/multilane_integer_register_alu.sv @@
// Top level of the multilane integer register ALU: lane register files,
// execute datapath and output register. Depends on mira_pkg.
`default_nettype none

// Usage
// The input channel (in_valid, in_ready, in_data) takes one word per
// cycle unless a multiply or a stalled receiver holds it. A word either
// executes one integer instruction on all eight lanes at once, writes the
// immediate into one register of one lane, or reads one register back.
// Every input word yields exactly one output word on (out_valid,
// out_ready, out_data), carrying the destination register of the selected
// lane after the step and the end-of-program flag for executes. A word is
// registered in the execute register on acceptance and its result then
// goes to the output register. The three multiply instructions stay
// longer in the execute register: the 64 by 64 product is built from four
// 32 by 32 partial products that are registered before they are summed,
// and no new word is taken until the multiply is done.
// When the receiver stalls, the output register holds its word and the
// execute register holds the next, after which in_ready falls.
// Reset clears every register of every lane to zero and empties both
// stages.
module multilane_integer_register_alu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mira_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mira_pkg::out_word_t     out_data
);

  localparam int Lanes = mira_pkg::LaneCount;
  localparam int Regs  = mira_pkg::RegCount;
  localparam int DW    = mira_pkg::DataW;
  localparam int HW    = mira_pkg::HalfW;

  // Lane register files, held in flip-flops so that every lane can read two
  // registers and, for a swap, write two in the same cycle.
  logic [DW-1:0] rf [Lanes][Regs];

  // Execute register and multiply phase.
  logic               stage_valid;
  mira_pkg::in_word_t stage;
  logic               mul_phase;

  // Registered partial products, one set per lane.
  logic [DW-1:0] pp_ll [Lanes];
  logic [DW-1:0] pp_lh [Lanes];
  logic [DW-1:0] pp_hl [Lanes];
  logic [DW-1:0] pp_hh [Lanes];

  mira_pkg::act_e                  op;
  logic [mira_pkg::RegIdxW-1:0]    dst_idx;
  logic [mira_pkg::RegIdxW-1:0]    src_idx;
  logic [mira_pkg::LaneIdxW-1:0]   lane_idx;
  logic                            is_mul;
  logic                            is_exec;
  logic                            exec_done;
  logic                            out_free;
  logic                            fire;

  logic [DW-1:0] d_val   [Lanes];
  logic [DW-1:0] s_val   [Lanes];
  logic [DW-1:0] new_dst [Lanes];

  mira_pkg::out_word_t result;

  assign op       = mira_pkg::act_e'(stage.action);
  assign dst_idx  = stage.dst_reg[mira_pkg::RegIdxW-1:0];
  assign src_idx  = stage.src_reg[mira_pkg::RegIdxW-1:0];
  assign lane_idx = stage.lane_select[mira_pkg::LaneIdxW-1:0];

  assign is_mul  = (op == mira_pkg::ACT_IMUL) || (op == mira_pkg::ACT_IMULH) ||
                   (op == mira_pkg::ACT_ISMULH);
  assign is_exec = (stage.action <= mira_pkg::ACT_ISMULH);

  // A multiply completes once mul_phase is set, after its partial products are registered.
  assign exec_done = stage_valid && (!is_mul || mul_phase);
  assign out_free  = !out_valid || out_ready;
  assign fire      = exec_done && out_free;
  assign in_ready  = !stage_valid || fire;

  // Per-lane execute datapath.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      logic [2*DW-1:0]              prod;
      logic [2*DW-1:0]              rot_r;
      logic [2*DW-1:0]              rot_l;
      logic [DW-1:0]                hi_s;
      logic [mira_pkg::RotW-1:0]    amt;
      d_val[l] = rf[l][dst_idx];
      s_val[l] = rf[l][src_idx];
      amt      = s_val[l][mira_pkg::RotW-1:0];
      rot_r    = {d_val[l], d_val[l]} >> amt;
      rot_l    = {d_val[l], d_val[l]} << amt;
      prod     = {pp_hh[l], pp_ll[l]} + {{HW{1'b0}}, pp_lh[l], {HW{1'b0}}} +
                 {{HW{1'b0}}, pp_hl[l], {HW{1'b0}}};
      // Signed high half: correct the unsigned product for negative operands.
      hi_s     = prod[2*DW-1:DW] - (d_val[l][DW-1] ? s_val[l] : '0) -
                 (s_val[l][DW-1] ? d_val[l] : '0);
      case (op)
        mira_pkg::ACT_IADD_RS: new_dst[l] = d_val[l] + (s_val[l] << stage.shift_amount) +
                                            stage.immediate;
        mira_pkg::ACT_ISUB:    new_dst[l] = d_val[l] - s_val[l];
        mira_pkg::ACT_IMUL:    new_dst[l] = prod[DW-1:0];
        mira_pkg::ACT_INEG:    new_dst[l] = ~d_val[l] + DW'(1);
        mira_pkg::ACT_IXOR:    new_dst[l] = d_val[l] ^ s_val[l];
        mira_pkg::ACT_IROR:    new_dst[l] = rot_r[DW-1:0];
        mira_pkg::ACT_IROL:    new_dst[l] = rot_l[2*DW-1:DW];
        mira_pkg::ACT_ISWAP:   new_dst[l] = s_val[l];
        mira_pkg::ACT_IMULH:   new_dst[l] = prod[2*DW-1:DW];
        mira_pkg::ACT_ISMULH:  new_dst[l] = hi_s;
        default:               new_dst[l] = d_val[l];
      endcase
    end
  end

  // The reported value is the destination register of the selected lane
  // as it stands after this word.
  always_comb begin
    result.program_done = is_exec && stage.end_of_program;
    if (is_exec) begin
      result.reg_value = new_dst[lane_idx];
    end else if (op == mira_pkg::ACT_WRITE) begin
      result.reg_value = stage.immediate;
    end else begin
      result.reg_value = d_val[lane_idx];
    end
  end

  // Partial products are registered while a multiply waits in the execute
  // register; the register file cannot change until that multiply retires.
  always_ff @(posedge clk) begin
    for (int l = 0; l < Lanes; l++) begin
      pp_ll[l] <= DW'(d_val[l][HW-1:0])  * DW'(s_val[l][HW-1:0]);
      pp_lh[l] <= DW'(d_val[l][HW-1:0])  * DW'(s_val[l][DW-1:HW]);
      pp_hl[l] <= DW'(d_val[l][DW-1:HW]) * DW'(s_val[l][HW-1:0]);
      pp_hh[l] <= DW'(d_val[l][DW-1:HW]) * DW'(s_val[l][DW-1:HW]);
    end
  end

  // Register file write-back. A swap of a register with itself writes
  // nothing but the destination, which keeps its value.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < Lanes; l++) begin
        for (int r = 0; r < Regs; r++) begin
          rf[l][r] <= '0;
        end
      end
    end else if (fire) begin
      if (op == mira_pkg::ACT_ISWAP) begin
        for (int l = 0; l < Lanes; l++) begin
          if (src_idx != dst_idx) begin
            rf[l][src_idx] <= d_val[l];
          end
          rf[l][dst_idx] <= s_val[l];
        end
      end else if (is_exec) begin
        for (int l = 0; l < Lanes; l++) begin
          rf[l][dst_idx] <= new_dst[l];
        end
      end else if (op == mira_pkg::ACT_WRITE) begin
        rf[lane_idx][dst_idx] <= stage.immediate;
      end
    end
  end

  // Execute register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      mul_phase   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (fire || !stage_valid) begin
        mul_phase <= 1'b0;
      end else if (is_mul) begin
        mul_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_multilane_integer_register_alu.sv @@
// Self-checking testbench for the multilane integer register ALU: directed and
// random instruction streams, checked word by word against a behavioural copy
// of the eight lane register files. Depends on mira_pkg and the RTL top level.
`default_nettype none

module tb_multilane_integer_register_alu;
  import mira_pkg::*;

  // Action codes that the block must ignore apart from reporting a value.
  localparam logic [3:0] ACT_UNUSED_LO = 4'd12;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  // Generous bound for about 500 words, each with idle bursts on either
  // side plus the multiply bubble.
  localparam int unsigned CycleLimit = 200000;
  // Two stages plus the multiply bubble, with spare margin on top.
  localparam int unsigned TailCycles = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  multilane_integer_register_alu dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Behavioural copy of the register files, and the results it predicts in
  // the order the block has to deliver them.
  logic [DataW-1:0] lane_regs [LaneCount][RegCount];
  out_word_t        expected_results [$];

  // Shared bookkeeping. full_rate switches off all idling on both sides;
  // valid_driven mirrors what has been scheduled on in_valid so that the
  // sender never places two assignments on it within one time step.
  bit          full_rate = 1'b0;
  bit          valid_driven = 1'b0;
  int unsigned fault_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_at_full_rate = 0;
  int unsigned results_checked = 0;
  int unsigned programs_ended = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;

  // Only the first ten faults are described in full; the rest are counted.
  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("mismatch %0d at cycle %0d: %s", fault_count, cycle_count, what);
    end
  endfunction

  // Applies one word to the register files and returns the result word the
  // block should report for it. Register and lane indices are reduced to the
  // low index bits, which is the modulo reduction for power-of-two counts.
  function automatic out_word_t alu_step(input in_word_t w);
    logic [DataW-1:0]          d;
    logic [DataW-1:0]          s;
    logic [DataW-1:0]          v;
    logic [2*DataW-1:0]        wide;
    logic signed [2*DataW-1:0] swide;
    logic [RegIdxW-1:0]        di;
    logic [RegIdxW-1:0]        si;
    logic [LaneIdxW-1:0]       li;
    int unsigned               ln;
    out_word_t                 r;
    di = w.dst_reg[RegIdxW-1:0];
    si = w.src_reg[RegIdxW-1:0];
    li = w.lane_select[LaneIdxW-1:0];
    if (w.action <= ACT_ISMULH) begin
      for (ln = 0; ln < LaneCount; ln++) begin
        d = lane_regs[ln][di];
        s = lane_regs[ln][si];
        if (w.action == ACT_ISWAP) begin
          // Exchanging a register with itself leaves it as it is.
          lane_regs[ln][di] = s;
          lane_regs[ln][si] = d;
        end else begin
          case (w.action)
            ACT_IADD_RS: v = d + (s << w.shift_amount) + w.immediate;
            ACT_ISUB:    v = d - s;
            ACT_IMUL:    v = d * s;
            ACT_INEG:    v = -d;
            ACT_IXOR:    v = d ^ s;
            ACT_IROR: begin
              wide = {d, d} >> s[RotW-1:0];
              v = wide[DataW-1:0];
            end
            ACT_IROL: begin
              wide = {d, d} << s[RotW-1:0];
              v = wide[2*DataW-1:DataW];
            end
            ACT_IMULH: begin
              wide = {{DataW{1'b0}}, d} * {{DataW{1'b0}}, s};
              v = wide[2*DataW-1:DataW];
            end
            ACT_ISMULH: begin
              swide = $signed({{DataW{d[DataW-1]}}, d}) * $signed({{DataW{s[DataW-1]}}, s});
              v = swide[2*DataW-1:DataW];
            end
            default: v = d;
          endcase
          lane_regs[ln][di] = v;
        end
      end
    end else if (w.action == ACT_WRITE) begin
      lane_regs[li][di] = w.immediate;
    end
    r.reg_value    = lane_regs[li][di];
    r.program_done = (w.action <= ACT_ISMULH) ? w.end_of_program : 1'b0;
    return r;
  endfunction

  function automatic in_word_t mk_word(input logic [3:0] action, input logic [2:0] dst,
                                       input logic [2:0] src, input logic [1:0] sh,
                                       input logic [DataW-1:0] imm, input logic [2:0] lane,
                                       input logic eop);
    in_word_t w;
    w.action         = action;
    w.dst_reg        = dst;
    w.src_reg        = src;
    w.shift_amount   = sh;
    w.immediate      = imm;
    w.lane_select    = lane;
    w.end_of_program = eop;
    return w;
  endfunction

  // Register contents that tend to expose carry, sign and rotate faults.
  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 6))
      0:       v = '0;
      1:       v = '1;
      2:       v = {1'b1, {(DataW-1){1'b0}}};
      3:       v = {1'b0, {(DataW-1){1'b1}}};
      4:       v = 64'd1;
      5:       v = 64'($urandom_range(0, 127));
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pick_execute(input bit mul_heavy);
    logic [3:0] a;
    if (mul_heavy && $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 2))
        0:       a = ACT_IMUL;
        1:       a = ACT_IMULH;
        default: a = ACT_ISMULH;
      endcase
    end else begin
      a = 4'($urandom_range(ACT_IADD_RS, ACT_ISMULH));
    end
    return a;
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is not
  // lowered on acceptance, so a following word can go out back to back; an
  // idle burst, when one is drawn, drops valid first.
  task automatic send_word(input in_word_t w);
    if (!full_rate && $urandom_range(0, 4) == 0) begin
      if (valid_driven) begin
        in_valid <= 1'b0;
        valid_driven = 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (!valid_driven) begin
      in_valid <= 1'b1;
      valid_driven = 1'b1;
    end
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(alu_step(w));
    words_sent++;
    if (full_rate) words_at_full_rate++;
  endtask

  // Holds the sender off until every outstanding result has been taken,
  // then lets the pipeline run empty for TailCycles clock edges.
  task automatic settle();
    if (valid_driven) begin
      in_valid <= 1'b0;
      valid_driven = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Straight after reset a register reads as zero, checked on the first and
  // the last register and lane. The end-of-program bit on a read must not show up as program_done.
  task automatic test_reset_contents();
    send_word(mk_word(ACT_READ, 3'd0, 3'd0, 2'd0, '0, 3'd0, 1'b0));
    send_word(mk_word(ACT_READ, 3'd7, 3'd7, 2'd3, '1, 3'd7, 1'b1));
  endtask

  // One pass through every execute instruction and the write, with values chosen so that each
  // result is distinctive: all ones, the most negative number, mixed bits.
  task automatic test_each_operation();
    send_word(mk_word(ACT_WRITE, 3'd1, 3'd0, 2'd0, '1, 3'd0, 1'b0));
    send_word(mk_word(ACT_WRITE, 3'd2, 3'd0, 2'd0, 64'h8000_0000_0000_0000, 3'd7, 1'b0));
    send_word(mk_word(ACT_WRITE, 3'd3, 3'd0, 2'd0, 64'h0123_4567_89ab_cdef, 3'd3, 1'b0));
    send_word(mk_word(ACT_IADD_RS, 3'd0, 3'd1, 2'd3, '1, 3'd0, 1'b0));
    send_word(mk_word(ACT_IADD_RS, 3'd7, 3'd3, 2'd0, 64'd0, 3'd3, 1'b0));
    send_word(mk_word(ACT_ISUB, 3'd0, 3'd1, 2'd1, '0, 3'd0, 1'b0));
    send_word(mk_word(ACT_IMUL, 3'd3, 3'd3, 2'd0, '0, 3'd3, 1'b0));
    // Negating the most negative number gives it back.
    send_word(mk_word(ACT_INEG, 3'd2, 3'd5, 2'd0, '0, 3'd7, 1'b0));
    send_word(mk_word(ACT_IXOR, 3'd4, 3'd3, 2'd0, '0, 3'd3, 1'b0));
    send_word(mk_word(ACT_IROR, 3'd4, 3'd7, 2'd2, '0, 3'd3, 1'b0));
    send_word(mk_word(ACT_IROL, 3'd1, 3'd1, 2'd0, '0, 3'd0, 1'b0));
    send_word(mk_word(ACT_ISWAP, 3'd5, 3'd4, 2'd0, '0, 3'd3, 1'b0));
    send_word(mk_word(ACT_IMULH, 3'd1, 3'd1, 2'd0, '0, 3'd0, 1'b0));
    send_word(mk_word(ACT_ISMULH, 3'd2, 3'd2, 2'd0, '0, 3'd7, 1'b0));
    // Signed high product of minus one and a positive value is all ones.
    send_word(mk_word(ACT_WRITE, 3'd6, 3'd0, 2'd0, '1, 3'd7, 1'b0));
    send_word(mk_word(ACT_ISMULH, 3'd6, 3'd2, 2'd0, '0, 3'd7, 1'b1));
  endtask

  // The corner behaviour: rotating by a multiple of 64, swapping a register
  // with itself, unused action codes, and end-of-program on non-executes.
  task automatic test_open_cases();
    send_word(mk_word(ACT_WRITE, 3'd0, 3'd0, 2'd0, 64'd64, 3'd3, 1'b1));
    send_word(mk_word(ACT_IROR, 3'd4, 3'd0, 2'd0, '0, 3'd3, 1'b0));
    send_word(mk_word(ACT_ISWAP, 3'd5, 3'd5, 2'd0, '0, 3'd3, 1'b0));
    send_word(mk_word(ACT_UNUSED_LO, 3'd5, 3'd2, 2'd1, '1, 3'd3, 1'b1));
    send_word(mk_word(ACT_UNUSED_HI, 3'd2, 3'd6, 2'd2, '0, 3'd7, 1'b1));
    send_word(mk_word(ACT_READ, 3'd4, 3'd1, 2'd0, '0, 3'd3, 1'b0));
  endtask

  // Short programs of random instructions ending with end_of_program on an
  // execute, mixed with register loads, read-backs and the odd unused code.
  // Writes use pointed operand values so the arithmetic sees its corners.
  task automatic run_programs(input int unsigned word_budget, input bit mul_heavy);
    in_word_t    w;
    int unsigned sent;
    int unsigned prog_len;
    int unsigned stp;
    int unsigned r;
    sent = 0;
    while (sent < word_budget) begin
      prog_len = $urandom_range(2, 12);
      for (stp = 0; stp < prog_len; stp++) begin
        w.action         = 4'($urandom_range(0, 15));
        w.dst_reg        = 3'($urandom_range(0, 7));
        w.src_reg        = 3'($urandom_range(0, 7));
        w.shift_amount   = 2'($urandom_range(0, 3));
        w.immediate      = {$urandom(), $urandom()};
        w.lane_select    = 3'($urandom_range(0, 7));
        w.end_of_program = 1'($urandom_range(0, 1));
        r = (stp + 1 == prog_len) ? 99 : $urandom_range(0, 99);
        if (r < 14) begin
          w.action    = ACT_WRITE;
          w.immediate = pick_operand();
        end else if (r < 22) begin
          w.action = ACT_READ;
        end else if (r < 25) begin
          w.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end else begin
          w.action         = pick_execute(mul_heavy);
          w.end_of_program = (stp + 1 == prog_len);
        end
        send_word(w);
        sent++;
      end
    end
  endtask

  task automatic test_random_programs();
    run_programs(360, 1'b0);
  endtask

  // No idling on either side, with many multiplies, so that the multiply
  // bubble meets back-to-back words and a full output register.
  task automatic test_full_rate();
    full_rate = 1'b1;
    run_programs(120, 1'b1);
  endtask

  // Receiver: takes result words, compares them with the oldest prediction
  // and stalls in random bursts unless the run is at full rate.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_fault($sformatf("unexpected result word: reg_value %h program_done %b",
                               out_data.reg_value, out_data.program_done));
        end else begin
          want = expected_results.pop_front();
          if (out_data.reg_value !== want.reg_value) begin
            note_fault($sformatf("reg_value expected %h actual %h",
                                 want.reg_value, out_data.reg_value));
          end
          if (out_data.program_done !== want.program_done) begin
            note_fault($sformatf("program_done expected %b actual %b",
                                 want.program_done, out_data.program_done));
          end
          results_checked++;
          if (want.program_done) programs_ended++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!full_rate && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("tb_multilane_integer_register_alu: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (lane_regs[l, r]) lane_regs[l][r] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_contents();
    test_each_operation();
    test_open_cases();
    settle();
    test_random_programs();
    settle();
    test_full_rate();
    settle();
    $display("summary: %0d words sent, %0d of them with no idling, %0d results checked",
             words_sent, words_at_full_rate, results_checked);
    $display("summary: %0d programs ended, %0d mismatches", programs_ended, fault_count);
    if (fault_count == 0) begin
      $display("tb_multilane_integer_register_alu: done, clean");
    end else begin
      $display("tb_multilane_integer_register_alu: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
